// ===== rtl/core/fbmd_pkg.sv =====
// ----------------------------------------------------------------------------
// fbmd_pkg
// Types, register indexes and the round function shared by the Feistel
// decryptor and its round cells.
// ----------------------------------------------------------------------------
package fbmd_pkg;

    typedef enum logic [1:0] {
        F_OR_XOR_RSH = 2'd0,
        F_XOR_AND_KSH = 2'd1,
        F_OR_XOR_KSH = 2'd2,
        F_XOR_AND_RSH = 2'd3
    } t_fvar;

    typedef enum logic [1:0] {
        MODE_ECB = 2'd0,
        MODE_CBC = 2'd1,
        MODE_CFB = 2'd2,
        MODE_CTR = 2'd3
    } t_mode;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_F_VARIANT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAIN_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ONE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_TWO = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_THREE = 3'd4;

    localparam logic [7:0] KEY_ONE_RST = 8'd217;
    localparam logic [7:0] KEY_TWO_RST = 8'd108;
    localparam logic [7:0] KEY_THREE_RST = 8'd80;

    localparam int NUM_ROUNDS = 3;

    // p/q halves in flight, the final xor mask and the direction
    typedef struct packed {
        logic [7:0] p;
        logic [7:0] q;
        logic [7:0] mask_l;
        logic [7:0] mask_r;
        logic       enc;
    } t_item;

    function automatic logic [7:0] round_f(input t_fvar v, input logic [7:0] r,
                                           input logic [7:0] k);
        logic [7:0] res;
        unique case (v)
            F_OR_XOR_RSH:  res = (r | k) ^ ((r >> 4) & k);
            F_XOR_AND_KSH: res = (r ^ k) & ((k >> 4) | r);
            F_OR_XOR_KSH:  res = (r | k) ^ ((k >> 4) & r);
            F_XOR_AND_RSH: res = (r ^ k) & ((r >> 4) | k);
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/core/fbmd_cell.sv =====
// ----------------------------------------------------------------------------
// fbmd_cell
// One registered Feistel round: (p, q) becomes (q, p ^ F(q, k)), with the
// key picked by the direction that travels with the block.
// ----------------------------------------------------------------------------
module fbmd_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fbmd_pkg::t_fvar    i_fvar,
    input  logic [7:0]         i_key_enc,
    input  logic [7:0]         i_key_dec,
    input  logic               i_valid,
    input  fbmd_pkg::t_item    i_item,
    output logic               o_ready,
    output logic               o_valid,
    output fbmd_pkg::t_item    o_item,
    input  logic               i_ready
);
    import fbmd_pkg::*;

    logic       r_valid;
    t_item      r_item;
    t_item      n_item;
    logic [7:0] key;

    always_comb begin
        key = i_item.enc ? i_key_enc : i_key_dec;
        n_item = i_item;
        n_item.p = i_item.q;
        n_item.q = i_item.p ^ round_f(i_fvar, i_item.q, key);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item = r_item;

endmodule

// ===== rtl/core/feistel8_block_mode_decrypt.sv =====
// ----------------------------------------------------------------------------
// feistel8_block_mode_decrypt
// Streaming decryptor for a 16-bit, 3-round Feistel cipher in ECB, CBC, CFB
// or counter mode.
//
// Input channel: i_valid / o_stall carry one ciphertext block per request
// (i_cipher_left, i_cipher_right, i_first_block). Output channel:
// o_valid / i_stall carry one plaintext block (o_plain_left, o_plain_right).
// In CBC and CFB a request with i_first_block set loads the IV and gives no
// output; every other request gives exactly one output, in order.
// Chaining state and the counter are updated as a request is taken, so a
// new request can be taken on every clock while o_stall is low. The three
// rounds run in a row of three registered round cells followed by an
// output register; throughput is one block per cycle unless stalled.
// When the receiver stalls, the output register holds its block and the
// cells keep filling; o_stall rises only once every cell is full.
// Reset (synchronous, active low) empties the pipeline, clears the chaining
// state and the counter and loads the default round keys and modes.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while
// no blocks are in flight.
// ----------------------------------------------------------------------------
module feistel8_block_mode_decrypt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fbmd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [fbmd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [7:0]                     i_cipher_left,
    input  logic [7:0]                     i_cipher_right,
    input  logic                           i_first_block,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [7:0]                     o_plain_left,
    output logic [7:0]                     o_plain_right
);
    import fbmd_pkg::*;

    t_fvar      r_fvar;
    t_mode      r_mode;
    logic [7:0] r_key [NUM_ROUNDS];
    logic [7:0] r_chain_l;
    logic [7:0] r_chain_r;
    logic [7:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_pl;
    logic [7:0] r_pr;

    logic       accept;
    logic       gives_out;
    logic [7:0] idx_eff;
    logic [7:0] ctr_a;
    t_item      in_item;

    logic       c_valid [NUM_ROUNDS+1];
    t_item      c_item  [NUM_ROUNDS+1];
    logic       c_ready [NUM_ROUNDS+1];
    logic       out_ready;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fvar <= F_OR_XOR_KSH;
            r_mode <= MODE_ECB;
            r_key[0] <= KEY_ONE_RST;
            r_key[1] <= KEY_TWO_RST;
            r_key[2] <= KEY_THREE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_F_VARIANT:  r_fvar <= t_fvar'(i_cfg_data[1:0]);
                CFG_CHAIN_MODE: r_mode <= t_mode'(i_cfg_data[1:0]);
                CFG_KEY_ONE:    r_key[0] <= i_cfg_data;
                CFG_KEY_TWO:    r_key[1] <= i_cfg_data;
                CFG_KEY_THREE:  r_key[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign accept = i_valid && !o_stall;
    assign idx_eff = i_first_block ? 8'd0 : r_idx;
    assign ctr_a = round_f(r_fvar, idx_eff, r_key[0]);

    // block preparation for the first cell
    always_comb begin
        in_item.p = i_cipher_left;
        in_item.q = i_cipher_right;
        in_item.mask_l = 8'd0;
        in_item.mask_r = 8'd0;
        in_item.enc = 1'b0;
        gives_out = 1'b1;
        unique case (r_mode)
            MODE_ECB: begin
            end
            MODE_CBC: begin
                in_item.mask_l = r_chain_l;
                in_item.mask_r = r_chain_r;
                gives_out = !i_first_block;
            end
            MODE_CFB: begin
                in_item.p = r_chain_l;
                in_item.q = r_chain_r;
                in_item.mask_l = i_cipher_left;
                in_item.mask_r = i_cipher_right;
                in_item.enc = 1'b1;
                gives_out = !i_first_block;
            end
            MODE_CTR: begin
                in_item.p = ctr_a;
                in_item.q = ctr_a;
                in_item.mask_l = i_cipher_left;
                in_item.mask_r = i_cipher_right;
                in_item.enc = 1'b1;
            end
        endcase
    end

    // chaining state and counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain_l <= 8'd0;
            r_chain_r <= 8'd0;
            r_idx <= 8'd0;
        end else if (accept) begin
            unique case (r_mode)
                MODE_ECB: r_idx <= idx_eff;
                MODE_CBC, MODE_CFB: begin
                    r_chain_l <= i_cipher_left;
                    r_chain_r <= i_cipher_right;
                end
                MODE_CTR: r_idx <= idx_eff + 8'd1;
            endcase
        end
    end

    // row of round cells
    assign c_valid[0] = i_valid && gives_out;
    assign c_item[0] = in_item;
    assign o_stall = !c_ready[0];

    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_cell
        fbmd_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_fvar    (r_fvar),
            .i_key_enc (r_key[g]),
            .i_key_dec (r_key[NUM_ROUNDS-1-g]),
            .i_valid   (c_valid[g]),
            .i_item    (c_item[g]),
            .o_ready   (c_ready[g]),
            .o_valid   (c_valid[g+1]),
            .o_item    (c_item[g+1]),
            .i_ready   (c_ready[g+1])
        );
    end

    // output register
    assign out_ready = !r_out_valid || !i_stall;
    assign c_ready[NUM_ROUNDS] = out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= c_valid[NUM_ROUNDS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && c_valid[NUM_ROUNDS]) begin
            r_pl <= c_item[NUM_ROUNDS].q ^ c_item[NUM_ROUNDS].mask_l;
            r_pr <= c_item[NUM_ROUNDS].p ^ c_item[NUM_ROUNDS].mask_r;
        end
    end

    assign o_valid = r_out_valid;
    assign o_plain_left = r_pl;
    assign o_plain_right = r_pr;

    // back-pressure reaches the input only with the output full
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_out_valid && i_stall))
        else $error("input stalled with output register free");

    a_ctr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_mode == MODE_CTR && !i_first_block) |=>
        (r_idx == $past(r_idx) + 8'd1))
        else $error("counter did not advance");

    a_chain_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (r_mode == MODE_CBC || r_mode == MODE_CFB)) |=>
        (r_chain_l == $past(i_cipher_left) && r_chain_r == $past(i_cipher_right)))
        else $error("chaining block not stored");

    a_iv_no_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_first_block && (r_mode == MODE_CBC || r_mode == MODE_CFB))
        |=> !c_valid[1] || $past(!c_ready[1]))
        else $error("iv request entered the round cells");

endmodule

// ===== tb/sv/fbmd_result_checker.sv =====
// ----------------------------------------------------------------------------
// fbmd_result_checker
// Watches both channels and the register port of the Feistel block-mode
// decryptor. Keeps its own copy of the keys, modes, chaining block and
// counter, works out the plaintext for every ciphertext request taken that
// gives one and compares each plaintext request given, in order, against it.
// ----------------------------------------------------------------------------
module fbmd_result_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fbmd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fbmd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic [7:0]                      i_cipher_left,
    input  logic [7:0]                      i_cipher_right,
    input  logic                            i_first_block,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic [7:0]                      i_plain_left,
    input  logic [7:0]                      i_plain_right,
    output int                              o_mismatches,
    output int                              o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import fbmd_pkg::*;

    t_fvar       fvar;
    t_mode       mode;
    logic [7:0]  round_key [NUM_ROUNDS];
    logic [15:0] chain;
    logic [7:0]  block_count;
    logic [15:0] plaintext_queue [$];
    logic [15:0] want;
    int          errors = 0;

    function automatic logic [7:0] round_mix(input logic [7:0] r, input logic [7:0] k);
        logic [7:0] v;
        case (fvar)
            F_OR_XOR_RSH:  v = (r | k) ^ ((r >> 4) & k);
            F_XOR_AND_KSH: v = (r ^ k) & ((k >> 4) | r);
            F_XOR_AND_RSH: v = (r ^ k) & ((r >> 4) | k);
            default:       v = (r | k) ^ ((k >> 4) & r);
        endcase
        return v;
    endfunction

    function automatic logic [15:0] feistel_encrypt(input logic [7:0] l, input logic [7:0] r);
        logic [7:0] nr;
        for (int i = 0; i < NUM_ROUNDS; i++) begin
            nr = l ^ round_mix(r, round_key[i]);
            l = r;
            r = nr;
        end
        return {r, l};
    endfunction

    function automatic logic [15:0] feistel_decrypt(input logic [7:0] l, input logic [7:0] r);
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] na;
        a = r;
        b = l;
        for (int i = NUM_ROUNDS - 1; i >= 0; i--) begin
            na = b ^ round_mix(a, round_key[i]);
            b = a;
            a = na;
        end
        return {a, b};
    endfunction

    function automatic void predict_plaintext(input logic [7:0] cl, input logic [7:0] cr,
                                              input logic first);
        logic [7:0] mixed;
        case (mode)
            MODE_CBC, MODE_CFB: begin
                if (first) begin
                    chain = {cl, cr};
                end else begin
                    if (mode == MODE_CBC) begin
                        plaintext_queue.push_back(feistel_decrypt(cl, cr) ^ chain);
                    end else begin
                        plaintext_queue.push_back({cl, cr} ^
                                                  feistel_encrypt(chain[15:8], chain[7:0]));
                    end
                    chain = {cl, cr};
                end
            end
            MODE_CTR: begin
                if (first) block_count = 8'd0;
                mixed = round_mix(block_count, round_key[0]);
                plaintext_queue.push_back({cl, cr} ^ feistel_encrypt(mixed, mixed));
                block_count = block_count + 8'd1;
            end
            default: begin
                if (first) block_count = 8'd0;
                plaintext_queue.push_back(feistel_decrypt(cl, cr));
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fvar = F_OR_XOR_KSH;
            mode = MODE_ECB;
            round_key[0] = KEY_ONE_RST;
            round_key[1] = KEY_TWO_RST;
            round_key[2] = KEY_THREE_RST;
            chain = 16'd0;
            block_count = 8'd0;
            plaintext_queue.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_F_VARIANT:  fvar = t_fvar'(i_cfg_data[1:0]);
                    CFG_CHAIN_MODE: mode = t_mode'(i_cfg_data[1:0]);
                    CFG_KEY_ONE:    round_key[0] = i_cfg_data[7:0];
                    CFG_KEY_TWO:    round_key[1] = i_cfg_data[7:0];
                    CFG_KEY_THREE:  round_key[2] = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                predict_plaintext(i_cipher_left, i_cipher_right, i_first_block);
            end
            if (i_out_valid && !i_out_stall) begin
                if (plaintext_queue.size() == 0) begin
                    if (errors < 10) begin
                        $display("unexpected plaintext %02h %02h with nothing outstanding",
                                 i_plain_left, i_plain_right);
                    end
                    errors++;
                end else begin
                    want = plaintext_queue.pop_front();
                    if (want[15:8] !== i_plain_left || want[7:0] !== i_plain_right) begin
                        if (errors < 10) begin
                            $display("plaintext mismatch: expected %02h %02h, got %02h %02h",
                                     want[15:8], want[7:0], i_plain_left, i_plain_right);
                        end
                        errors++;
                    end
                end
            end
        end
        o_outstanding <= plaintext_queue.size();
        o_mismatches <= errors;
    end

endmodule

// ===== tb/sv/feistel8_block_mode_decrypt_test.sv =====
// ----------------------------------------------------------------------------
// feistel8_block_mode_decrypt_test
// Drives ciphertext requests through the decryptor in all four chaining
// modes: a directed set of edge cases first, then phases of random messages
// under random keys and round functions, with a long counter-mode message
// that wraps the counter. Both sides idle at random; the receiver also holds
// off for a long stretch once. The checker beside the block gives the count
// of failures.
// ----------------------------------------------------------------------------
module feistel8_block_mode_decrypt_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fbmd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 60;
    localparam int SETTLE_CYCLES = 8;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [7:0]            i_cipher_left = 8'd0;
    logic [7:0]            i_cipher_right = 8'd0;
    logic                  i_first_block = 1'b0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [7:0]            o_plain_left;
    logic [7:0]            o_plain_right;

    int mismatches;
    int outstanding;
    int cycles = 0;
    bit calm = 1'b0;
    bit hold_req = 1'b0;

    feistel8_block_mode_decrypt i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cipher_left  (i_cipher_left),
        .i_cipher_right (i_cipher_right),
        .i_first_block  (i_first_block),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_plain_left   (o_plain_left),
        .o_plain_right  (o_plain_right)
    );

    fbmd_result_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_cipher_left  (i_cipher_left),
        .i_cipher_right (i_cipher_right),
        .i_first_block  (i_first_block),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_plain_left   (o_plain_left),
        .i_plain_right  (o_plain_right),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("feistel8_block_mode_decrypt test failed");
        $finish;
    end

    // receiver: random stall before each plaintext request, or one long hold
    initial begin
        int n;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                n = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                n = (calm || $urandom_range(0, 1)) ? 0 : $urandom_range(0, 18);
            end
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid || hold_req));
        end
    end

    // leaves the request up once taken
    task automatic send_block(input logic [7:0] cl, input logic [7:0] cr, input logic first);
        int gap;
        gap = (calm || $urandom_range(0, 1)) ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cipher_left <= cl;
        i_cipher_right <= cr;
        i_first_block <= first;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input t_fvar fv, input t_mode md, input logic [7:0] k1,
                             input logic [7:0] k2, input logic [7:0] k3);
        logic [CFG_DATA_W-1:0] word;
        drain();
        word = CFG_DATA_W'($urandom);
        word[1:0] = fv;
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_F_VARIANT;
        i_cfg_data <= word;
        @(posedge i_clk);
        word = CFG_DATA_W'($urandom);
        word[1:0] = md;
        i_cfg_idx <= CFG_CHAIN_MODE;
        i_cfg_data <= word;
        @(posedge i_clk);
        i_cfg_idx <= CFG_KEY_ONE;
        i_cfg_data <= k1;
        @(posedge i_clk);
        i_cfg_idx <= CFG_KEY_TWO;
        i_cfg_data <= k2;
        @(posedge i_clk);
        i_cfg_idx <= CFG_KEY_THREE;
        i_cfg_data <= k3;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_message(input int len);
        for (int j = 0; j < len; j++) begin
            send_block(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), j == 0);
        end
    endtask

    // mostly whole messages, some stray requests with a random start flag
    task automatic run_phase(input int n);
        int sent;
        int len;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 9) == 0) begin
                send_block(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1)));
                sent++;
            end else begin
                len = $urandom_range(1, 8);
                send_message(len);
                sent += len;
            end
        end
    endtask

    initial begin
        logic [7:0] k [3];
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // cbc with no iv yet, then a proper message
        configure(F_OR_XOR_KSH, MODE_CBC, KEY_ONE_RST, KEY_TWO_RST, KEY_THREE_RST);
        send_block(8'h3c, 8'ha5, 1'b0);
        send_block(8'hff, 8'h00, 1'b0);
        send_block(8'h12, 8'h34, 1'b1);
        send_block(8'h00, 8'hff, 1'b0);
        // mode change mid-message keeps the chaining block
        configure(F_OR_XOR_KSH, MODE_CFB, KEY_ONE_RST, KEY_TWO_RST, KEY_THREE_RST);
        send_block(8'h5a, 8'hc3, 1'b0);
        send_block(8'hff, 8'hff, 1'b1);
        send_block(8'h00, 8'h00, 1'b0);
        configure(F_OR_XOR_KSH, MODE_CTR, KEY_ONE_RST, KEY_TWO_RST, KEY_THREE_RST);
        send_block(8'h00, 8'h00, 1'b1);
        send_block(8'hff, 8'hff, 1'b0);
        send_block(8'h80, 8'h01, 1'b0);
        configure(F_OR_XOR_KSH, MODE_ECB, KEY_ONE_RST, KEY_TWO_RST, KEY_THREE_RST);
        send_block(8'h00, 8'h00, 1'b0);
        send_block(8'hff, 8'hff, 1'b1);
        send_block(8'h00, 8'hff, 1'b0);
        send_block(8'hff, 8'h00, 1'b0);
        configure(F_OR_XOR_RSH, MODE_ECB, 8'h00, 8'hff, 8'h0f);
        send_block(8'ha5, 8'h5a, 1'b0);
        configure(F_XOR_AND_KSH, MODE_ECB, 8'hff, 8'h00, 8'hf0);
        send_block(8'h5a, 8'ha5, 1'b0);
        configure(F_XOR_AND_RSH, MODE_CTR, 8'hff, 8'hff, 8'hff);
        send_block(8'h96, 8'h69, 1'b1);
        send_block(8'h0f, 8'hf0, 1'b0);

        for (int ph = 0; ph < 10; ph++) begin
            for (int i = 0; i < 3; i++) begin
                k[i] = (ph == 0) ? 8'h00 : (ph == 1) ? 8'hff : 8'($urandom);
            end
            configure(t_fvar'($urandom_range(0, 3)), t_mode'(ph % 4), k[0], k[1], k[2]);
            calm = (ph == 3 || ph == 6);
            if (ph == 6) hold_req = 1'b1;
            run_phase(35);
        end
        calm = 1'b0;

        // one long counter message so that the counter wraps
        configure(t_fvar'($urandom_range(0, 3)), MODE_CTR, 8'($urandom), 8'($urandom),
                  8'($urandom));
        send_message(280);
        drain();

        if (mismatches == 0 && outstanding == 0) begin
            $display("feistel8_block_mode_decrypt test passed");
        end else begin
            $display("feistel8_block_mode_decrypt test failed");
        end
        $finish;
    end

endmodule
